[src/sst_pkg.sv]
// shared types and constants for the scoped symbol table core
// no dependencies; used by the interfaces, the controller, the datapath and the checker
package sst_pkg;

    // field widths fixed by the command and result formats
    localparam int SYM_W       = 10;
    localparam int DECL_W      = 12;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 3;
    localparam int DEPTH_OUT_W = 7;

    // name map covers every interned index
    localparam int SYMBOLS = 1 << SYM_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_OPEN       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLOSE      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLASH_TEST = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CLASH      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DECL_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SCOPE_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_SCOPE   = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic clear_wr;     // clear one name map entry
        logic accept;       // capture a command beat, launch reads
        logic eval;         // finish a single-step command
        logic close_start;  // begin the walk of a closing scope
        logic walk_rd;      // read one declaration stack entry
        logic walk_wr;      // restore one hidden binding
        logic close_done;   // finish a close
    } sst_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;     // clearing the last name map entry
        logic close_go;     // captured close has a scope to close
        logic walk_more;    // entries remain in the closing scope
    } sst_stat_t;

endpackage

[src/sst_req_if.sv]
// command channel: valid/ready handshake carrying one command beat
// depends on sst_pkg
interface sst_req_if;
    logic                            valid;
    logic                            ready;
    logic [sst_pkg::CMD_W-1:0]       command;
    logic [sst_pkg::SYM_W-1:0]       symbol_index;
    logic [sst_pkg::DECL_W-1:0]      decl_id;

    modport source (output valid, output command, output symbol_index, output decl_id,
                    input ready);
    modport sink   (input valid, input command, input symbol_index, input decl_id,
                    output ready);
endinterface

[src/sst_rsp_if.sv]
// result channel: valid/ready handshake carrying one result beat
// depends on sst_pkg
interface sst_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [sst_pkg::STATUS_W-1:0]      status;
    logic                              found;
    logic [sst_pkg::DECL_W-1:0]        bound_decl;
    logic [sst_pkg::DEPTH_OUT_W-1:0]   scope_depth_now;
    logic                              all_ok;

    modport source (output valid, output status, output found, output bound_decl,
                    output scope_depth_now, output all_ok, input ready);
    modport sink   (input valid, input status, input found, input bound_decl,
                    input scope_depth_now, input all_ok, output ready);
endinterface

[src/sst_ctrl.sv]
// sequencing state machine of the scoped symbol table core
// depends on sst_pkg; drives the datapath through sst_ctl_t
module sst_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               rsp_ready,
    input  sst_pkg::sst_stat_t stat,
    output sst_pkg::sst_ctl_t  ctl,
    output logic               req_ready,
    output logic               rsp_valid
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_WALK,
        S_WALK_WR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clear_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                priority if (stat.close_go)
                begin
                    ctl.close_start = 1'b1;
                    state_next      = S_WALK;
                end
                else if (slot_free)
                begin
                    ctl.eval   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // result register still busy
                    state_next = S_LOOK;
                end
            end
            S_WALK:
            begin
                priority if (stat.walk_more)
                begin
                    ctl.walk_rd = 1'b1;
                    state_next  = S_WALK_WR;
                end
                else if (slot_free)
                begin
                    ctl.close_done = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK_WR:
            begin
                ctl.walk_wr = 1'b1;
                state_next  = S_WALK;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        priority if (ctl.eval || ctl.close_done)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

[src/sst_datapath.sv]
// name map, declaration stack, scope marks and result registers
// depends on sst_pkg; steered by sst_ctrl through sst_ctl_t
module sst_datapath #(
    parameter int DECL_STACK_DEPTH = 256,
    parameter int MAX_SCOPES       = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sst_pkg::sst_ctl_t                 ctl,
    output sst_pkg::sst_stat_t                stat,
    input  logic [sst_pkg::CMD_W-1:0]         req_command,
    input  logic [sst_pkg::SYM_W-1:0]         req_symbol_index,
    input  logic [sst_pkg::DECL_W-1:0]        req_decl_id,
    output logic [sst_pkg::STATUS_W-1:0]      status,
    output logic                              found,
    output logic [sst_pkg::DECL_W-1:0]        bound_decl,
    output logic [sst_pkg::DEPTH_OUT_W-1:0]   scope_depth_now,
    output logic                              all_ok
);

    localparam int SYM_W  = sst_pkg::SYM_W;
    localparam int DECL_W = sst_pkg::DECL_W;
    localparam int CMD_W  = sst_pkg::CMD_W;
    localparam int ST_W   = sst_pkg::STATUS_W;
    localparam int DOW    = sst_pkg::DEPTH_OUT_W;
    localparam int DW     = $clog2(MAX_SCOPES + 1);
    localparam int MW     = $clog2(MAX_SCOPES);
    localparam int HW     = $clog2(DECL_STACK_DEPTH + 1);
    localparam int PW     = $clog2(DECL_STACK_DEPTH);
    localparam int NMW    = 1 + DECL_W + DW;
    localparam int SEW    = SYM_W + NMW;

    // storage: map entry {valid, decl, depth}, stack entry {sym, hidden entry}
    logic [NMW-1:0] nm_mem [sst_pkg::SYMBOLS];
    logic [SEW-1:0] ds_mem [DECL_STACK_DEPTH];
    logic [HW-1:0]  mk_mem [MAX_SCOPES];

    logic [NMW-1:0]    nm_rd_reg;
    logic [SEW-1:0]    ds_rd_reg;
    logic [HW-1:0]     mk_rd_reg;

    logic [CMD_W-1:0]  cmd_reg;
    logic [SYM_W-1:0]  sym_reg;
    logic [DECL_W-1:0] decl_reg;
    logic [HW-1:0]     keep_reg;

    logic [SYM_W-1:0]  clr_addr_reg;
    logic [HW-1:0]     height_reg;
    logic [HW-1:0]     height_next;
    logic [DW-1:0]     depth_reg;
    logic [DW-1:0]     depth_next;
    logic              err_reg;
    logic              err_next;
    logic [HW-1:0]     walk_reg;

    logic [ST_W-1:0]   status_reg;
    logic [ST_W-1:0]   status_next;
    logic              found_reg;
    logic              found_next;
    logic [DECL_W-1:0] bound_reg;
    logic [DECL_W-1:0] bound_next;
    logic [DOW-1:0]    depth_out_reg;
    logic              ok_out_reg;

    logic              cur_valid;
    logic [DECL_W-1:0] cur_decl;
    logic [DW-1:0]     cur_depth;
    logic              here;
    logic [SYM_W-1:0]  ds_sym;
    logic [NMW-1:0]    ds_hidden;
    logic [DW-1:0]     depth_dec;
    logic [HW-1:0]     keep_now;
    logic [DW+DOW-1:0] depth_ext;

    logic              ev_nm_we;
    logic              ev_ds_we;
    logic              ev_mk_we;
    logic              fin;

    logic              nm_we;
    logic [SYM_W-1:0]  nm_waddr;
    logic [NMW-1:0]    nm_wdata;

    assign cur_valid = nm_rd_reg[NMW-1];
    assign cur_decl  = nm_rd_reg[NMW-2 -: DECL_W];
    assign cur_depth = nm_rd_reg[DW-1:0];
    assign here      = cur_valid && (cur_depth == depth_reg);
    assign ds_sym    = ds_rd_reg[SEW-1 -: SYM_W];
    assign ds_hidden = ds_rd_reg[NMW-1:0];
    assign depth_dec = depth_reg - DW'(1);
    assign keep_now  = (mk_rd_reg > height_reg) ? height_reg : mk_rd_reg;
    assign fin       = ctl.eval || ctl.close_done;
    assign depth_ext = {{DOW{1'b0}}, depth_next};

    assign stat.clr_last  = (clr_addr_reg == SYM_W'(sst_pkg::SYMBOLS - 1));
    assign stat.close_go  = (cmd_reg == sst_pkg::CMD_CLOSE) && (depth_reg != '0);
    assign stat.walk_more = (walk_reg < height_reg);

    // result and state update of a finishing command
    always_comb
    begin
        status_next = sst_pkg::ST_OK;
        found_next  = 1'b0;
        bound_next  = '0;
        depth_next  = depth_reg;
        height_next = height_reg;
        err_next    = err_reg;
        ev_nm_we    = 1'b0;
        ev_ds_we    = 1'b0;
        ev_mk_we    = 1'b0;
        if (ctl.close_done)
        begin
            depth_next  = depth_dec;
            height_next = keep_reg;
        end
        else
        begin
            unique case (cmd_reg)
                sst_pkg::CMD_OPEN:
                begin
                    if (depth_reg >= DW'(MAX_SCOPES))
                    begin
                        status_next = sst_pkg::ST_SCOPE_FULL;
                        err_next    = 1'b1;
                    end
                    else
                    begin
                        ev_mk_we   = 1'b1;
                        depth_next = depth_reg + DW'(1);
                    end
                end
                sst_pkg::CMD_CLOSE:
                begin
                    // only reached with no scope open, a real close walks first
                    status_next = sst_pkg::ST_NO_SCOPE;
                    err_next    = 1'b1;
                end
                sst_pkg::CMD_INSERT:
                begin
                    priority if (here)
                    begin
                        status_next = sst_pkg::ST_CLASH;
                        found_next  = 1'b1;
                        bound_next  = cur_decl;
                        err_next    = 1'b1;
                    end
                    else if (height_reg >= HW'(DECL_STACK_DEPTH))
                    begin
                        status_next = sst_pkg::ST_DECL_FULL;
                        err_next    = 1'b1;
                    end
                    else
                    begin
                        ev_nm_we    = 1'b1;
                        ev_ds_we    = 1'b1;
                        height_next = height_reg + HW'(1);
                    end
                end
                sst_pkg::CMD_LOOKUP:
                begin
                    if (cur_valid)
                    begin
                        found_next = 1'b1;
                        bound_next = cur_decl;
                    end
                end
                sst_pkg::CMD_CLASH_TEST:
                begin
                    if (here)
                    begin
                        found_next = 1'b1;
                        bound_next = cur_decl;
                    end
                end
                default:
                begin
                    status_next = sst_pkg::ST_OK;
                end
            endcase
        end
    end

    // single write port of the name map
    always_comb
    begin
        nm_we    = 1'b0;
        nm_waddr = sym_reg;
        nm_wdata = {1'b1, decl_reg, depth_reg};
        priority if (ctl.clear_wr)
        begin
            nm_we    = 1'b1;
            nm_waddr = clr_addr_reg;
            nm_wdata = '0;
        end
        else if (ctl.walk_wr)
        begin
            nm_we    = 1'b1;
            nm_waddr = ds_sym;
            nm_wdata = ds_hidden;
        end
        else if (ctl.eval && ev_nm_we)
        begin
            nm_we = 1'b1;
        end
        else
        begin
            nm_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (nm_we)
        begin
            nm_mem[nm_waddr] <= nm_wdata;
        end
        if (ctl.accept)
        begin
            nm_rd_reg <= nm_mem[req_symbol_index];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.eval && ev_ds_we)
        begin
            ds_mem[height_reg[PW-1:0]] <= {sym_reg, nm_rd_reg};
        end
        if (ctl.walk_rd)
        begin
            ds_rd_reg <= ds_mem[walk_reg[PW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.eval && ev_mk_we)
        begin
            mk_mem[depth_reg[MW-1:0]] <= height_reg;
        end
        if (ctl.accept)
        begin
            mk_rd_reg <= mk_mem[depth_dec[MW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg  <= req_command;
            sym_reg  <= req_symbol_index;
            decl_reg <= req_decl_id;
        end
        if (ctl.close_start)
        begin
            keep_reg <= keep_now;
        end
        if (fin)
        begin
            status_reg    <= status_next;
            found_reg     <= found_next;
            bound_reg     <= bound_next;
            depth_out_reg <= depth_ext[DOW-1:0];
            ok_out_reg    <= !err_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            height_reg   <= '0;
            depth_reg    <= '0;
            err_reg      <= 1'b0;
            walk_reg     <= '0;
        end
        else
        begin
            if (ctl.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + SYM_W'(1);
            end
            if (fin)
            begin
                height_reg <= height_next;
                depth_reg  <= depth_next;
                err_reg    <= err_next;
            end
            priority if (ctl.close_start)
            begin
                walk_reg <= keep_now;
            end
            else if (ctl.walk_wr)
            begin
                walk_reg <= walk_reg + HW'(1);
            end
            else
            begin
                walk_reg <= walk_reg;
            end
        end
    end

    assign status          = status_reg;
    assign found           = found_reg;
    assign bound_decl      = bound_reg;
    assign scope_depth_now = depth_out_reg;
    assign all_ok          = ok_out_reg;

endmodule

[src/scoped_symbol_table_core.sv]
// top level of the scoped symbol table core
// depends on sst_pkg, sst_req_if, sst_rsp_if, sst_ctrl and sst_datapath
//
//  channel  dir  beat contents
//  -------  ---  --------------------------------------------------------
//  req      in   command, symbol_index, decl_id
//  rsp      out  status, found, bound_decl, scope_depth_now, all_ok
//
// open, insert, lookup and clash test launch the map and scope mark reads
// at acceptance, then do the update and result load
// a close walks the entries of the closing scope one at a time, each read through
// the single declaration stack read port and restored through the map write port
// after reset the name map is cleared one entry a cycle, and req.ready
// stays low until the last entry is cleared
// a result waits in the rsp register while the next command is taken;
// that command finishes once the register is free
module scoped_symbol_table_core #(
    parameter int DECL_STACK_DEPTH = 256,
    parameter int MAX_SCOPES       = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    sst_req_if.sink   req,
    sst_rsp_if.source rsp
);

    sst_pkg::sst_ctl_t  ctl;
    sst_pkg::sst_stat_t stat;

    // sequencing: clear sweep, accept, evaluate, scope walk
    sst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .ctl       (ctl),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid)
    );

    // storage and result registers
    sst_datapath #(
        .DECL_STACK_DEPTH (DECL_STACK_DEPTH),
        .MAX_SCOPES       (MAX_SCOPES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .stat             (stat),
        .req_command      (req.command),
        .req_symbol_index (req.symbol_index),
        .req_decl_id      (req.decl_id),
        .status           (rsp.status),
        .found            (rsp.found),
        .bound_decl       (rsp.bound_decl),
        .scope_depth_now  (rsp.scope_depth_now),
        .all_ok           (rsp.all_ok)
    );

endmodule

[src/sst_checker.sv]
// port-level assertions for the scoped symbol table core, bound to the top level
// depends on sst_pkg and scoped_symbol_table_core
module sst_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic [sst_pkg::STATUS_W-1:0]      status,
    input logic [sst_pkg::DEPTH_OUT_W-1:0]   depth,
    input logic                              all_ok
);

    logic                            err_seen_reg;
    logic [sst_pkg::DEPTH_OUT_W-1:0] last_depth_reg;
    logic [sst_pkg::DEPTH_OUT_W-1:0] depth_step;
    logic                            rsp_fire;

    assign rsp_fire   = rsp_valid && rsp_ready;
    assign depth_step = depth - last_depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_seen_reg   <= 1'b0;
            last_depth_reg <= '0;
        end
        else if (rsp_fire)
        begin
            err_seen_reg   <= err_seen_reg || !all_ok;
            last_depth_reg <= depth;
        end
    end

    // nothing taken or shown once reset has been seen at an edge
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !req_ready && !rsp_valid)
        else $error("ready or valid high during reset");

    // one command at a time: no acceptance right after an acceptance
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("command taken in back-to-back cycles");

    // stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(all_ok))
        else $error("stalled result beat changed");

    // error flag is sticky and covers every error status
    a_sticky_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (err_seen_reg || status != sst_pkg::ST_OK) |-> !all_ok)
        else $error("all_ok high after an error");

    // depth moves by at most one scope between beats
    a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire |-> depth_step == 7'd0 || depth_step == 7'd1 || depth_step == 7'h7f)
        else $error("scope depth jumped");

endmodule

bind scoped_symbol_table_core sst_checker u_sst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .depth     (rsp.scope_depth_now),
    .all_ok    (rsp.all_ok)
);

[test/sst_table_checker.sv]
`timescale 1ns / 100ps
// result checker for the scoped symbol table core: watches both channels and
// predicts every result beat; depends on sst_pkg, sst_req_if and sst_rsp_if
module sst_table_checker #(
    parameter int DECL_STACK_DEPTH = 256,
    parameter int MAX_SCOPES       = 64
) (
    input  logic clk,
    input  logic rst_n,
    sst_req_if   req,
    sst_rsp_if   rsp,
    output int   fail_count,
    output int   pending_beats
);

    localparam int SYM_W       = sst_pkg::SYM_W;
    localparam int DECL_W      = sst_pkg::DECL_W;
    localparam int CMD_W       = sst_pkg::CMD_W;
    localparam int STATUS_W    = sst_pkg::STATUS_W;
    localparam int DEPTH_OUT_W = sst_pkg::DEPTH_OUT_W;
    localparam int SYMBOLS     = sst_pkg::SYMBOLS;

    typedef struct packed {
        logic                   valid;
        logic [DECL_W-1:0]      decl;
        logic [DEPTH_OUT_W-1:0] level;
    } map_entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   found;
        logic [DECL_W-1:0]      bound_decl;
        logic [DEPTH_OUT_W-1:0] scope_depth_now;
        logic                   all_ok;
    } table_result_t;

    map_entry_t       name_map     [SYMBOLS];
    logic [SYM_W-1:0] shadow_sym   [DECL_STACK_DEPTH];
    map_entry_t       shadow_entry [DECL_STACK_DEPTH];
    int unsigned      scope_mark   [MAX_SCOPES];
    int unsigned      shadow_height;
    int unsigned      scope_level;
    logic             error_seen;

    table_result_t    result_q [$];
    table_result_t    got_beat;
    table_result_t    want_beat;
    int               mismatches = 0;
    int               waiting    = 0;

    assign fail_count    = mismatches;
    assign pending_beats = waiting;

    function automatic table_result_t apply_command(logic [CMD_W-1:0] cmd,
                                                    logic [SYM_W-1:0] sym,
                                                    logic [DECL_W-1:0] decl);
        table_result_t res;
        map_entry_t    cur;
        logic          here;
        int unsigned   mark;
        res        = '0;
        res.status = sst_pkg::ST_OK;
        cur        = name_map[sym];
        here       = cur.valid && (int'(cur.level) == scope_level);
        case (cmd)
            sst_pkg::CMD_OPEN:
            begin
                if (scope_level >= MAX_SCOPES)
                begin
                    error_seen = 1'b1;
                    res.status = sst_pkg::ST_SCOPE_FULL;
                end
                else
                begin
                    scope_mark[scope_level] = shadow_height;
                    scope_level++;
                end
            end
            sst_pkg::CMD_CLOSE:
            begin
                if (scope_level == 0)
                begin
                    error_seen = 1'b1;
                    res.status = sst_pkg::ST_NO_SCOPE;
                end
                else
                begin
                    mark = scope_mark[scope_level-1];
                    if (mark > shadow_height)
                        mark = shadow_height;
                    // oldest first, so a name shadowed twice would end on its later hidden entry
                    for (int unsigned i = mark; i < shadow_height; i++)
                        name_map[shadow_sym[i]] = shadow_entry[i];
                    shadow_height = mark;
                    scope_level--;
                end
            end
            sst_pkg::CMD_INSERT:
            begin
                if (here)
                begin
                    error_seen     = 1'b1;
                    res.status     = sst_pkg::ST_CLASH;
                    res.found      = 1'b1;
                    res.bound_decl = cur.decl;
                end
                else if (shadow_height >= DECL_STACK_DEPTH)
                begin
                    error_seen = 1'b1;
                    res.status = sst_pkg::ST_DECL_FULL;
                end
                else
                begin
                    shadow_sym[shadow_height]   = sym;
                    shadow_entry[shadow_height] = cur;
                    shadow_height++;
                    name_map[sym] = '{valid: 1'b1, decl: decl,
                                      level: DEPTH_OUT_W'(scope_level)};
                end
            end
            sst_pkg::CMD_LOOKUP:
            begin
                if (cur.valid)
                begin
                    res.found      = 1'b1;
                    res.bound_decl = cur.decl;
                end
            end
            sst_pkg::CMD_CLASH_TEST:
            begin
                if (here)
                begin
                    res.found      = 1'b1;
                    res.bound_decl = cur.decl;
                end
            end
            default:
            begin
            end
        endcase
        res.scope_depth_now = DEPTH_OUT_W'(scope_level);
        res.all_ok          = !error_seen;
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SYMBOLS; i++)
                name_map[i] = '0;
            shadow_height = 0;
            scope_level   = 0;
            error_seen    = 1'b0;
            result_q.delete();
            waiting = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got_beat = '{status: rsp.status, found: rsp.found,
                             bound_decl: rsp.bound_decl,
                             scope_depth_now: rsp.scope_depth_now, all_ok: rsp.all_ok};
                if (result_q.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    want_beat = result_q.pop_front();
                    check_field("status", 32'(want_beat.status), 32'(got_beat.status));
                    check_field("found", 32'(want_beat.found), 32'(got_beat.found));
                    check_field("bound_decl", 32'(want_beat.bound_decl),
                                32'(got_beat.bound_decl));
                    check_field("scope_depth_now", 32'(want_beat.scope_depth_now),
                                32'(got_beat.scope_depth_now));
                    check_field("all_ok", 32'(want_beat.all_ok), 32'(got_beat.all_ok));
                end
            end
            if (req.valid && req.ready)
                result_q.insert(result_q.size(),
                                apply_command(req.command, req.symbol_index,
                                              req.decl_id));
            waiting = result_q.size();
        end
    end

endmodule

[test/scoped_symbol_table_core_tb.sv]
`timescale 1ns / 100ps
// testbench top for the scoped symbol table core: command stimulus and verdict
// depends on sst_pkg, sst_req_if, sst_rsp_if, sst_table_checker and the core
module scoped_symbol_table_core_tb;

    localparam int SYM_W   = sst_pkg::SYM_W;
    localparam int DECL_W  = sst_pkg::DECL_W;
    localparam int CMD_W   = sst_pkg::CMD_W;
    localparam int SYMBOLS = sst_pkg::SYMBOLS;

    localparam int DECL_DEPTH  = 256;
    localparam int SCOPE_LIMIT = 64;

    // beats that change or probe the table in the random part
    localparam int RANDOM_BEATS = 750;
    // a close walks up to the whole declaration stack
    localparam int DRAIN_CYCLES = 3 + 2 * DECL_DEPTH + 100;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sst_req_if req ();
    sst_rsp_if rsp ();

    int fail_count;
    int pending_beats;

    // sender burst bookkeeping and our own view of the nesting level,
    // used only to steer the command mix
    int burst_left = 0;
    int level_seen = 0;

    scoped_symbol_table_core #(
        .DECL_STACK_DEPTH (DECL_DEPTH),
        .MAX_SCOPES       (SCOPE_LIMIT)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    sst_table_checker #(
        .DECL_STACK_DEPTH (DECL_DEPTH),
        .MAX_SCOPES       (SCOPE_LIMIT)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_beats (pending_beats)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // hard stop well past the slowest legal run, including the map clear
    initial
    begin
        #4ms;
        $display("== FAIL ==");
        $finish;
    end

    // codes past the clash test are ignored by the core
    function automatic logic [CMD_W-1:0] ignored_cmd(int unsigned offset);
        return sst_pkg::CMD_CLASH_TEST + CMD_W'(offset);
    endfunction

    // mostly a small pool of names so shadowing and clashes are common
    function automatic logic [SYM_W-1:0] pick_symbol();
        if ($urandom_range(0, 9) < 7)
            return SYM_W'($urandom_range(0, 15));
        return SYM_W'($urandom_range(0, SYMBOLS - 1));
    endfunction

    // one command beat: drive at the edge, hold until the core takes it;
    // a gap only opens between bursts so valid never dips within a step
    task automatic issue(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym,
                         logic [DECL_W-1:0] decl);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 24);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.valid        <= 1'b1;
        req.command      <= cmd;
        req.symbol_index <= sym;
        req.decl_id      <= decl;
        do
            @(posedge clk);
        while (!req.ready);
        if (cmd == sst_pkg::CMD_OPEN && level_seen < SCOPE_LIMIT)
            level_seen++;
        else if (cmd == sst_pkg::CMD_CLOSE && level_seen > 0)
            level_seen--;
    endtask

    // receiver: stretches of always ready, random, mostly ready and sparse ready, plus
    // long hold-offs so the core backs up and drops req.ready
    initial
    begin
        int mode;
        int stretch;
        int stretch_no;
        rsp.ready  <= 1'b0;
        stretch_no = 0;
        @(posedge clk iff rst_n);
        forever
        begin
            stretch_no++;
            if (stretch_no == 6 || $urandom_range(0, 24) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(150, 250)) @(posedge clk);
            end
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(10, 60);
            repeat (stretch)
            begin
                case (mode)
                    0: rsp.ready <= 1'b1;
                    1: rsp.ready <= 1'($urandom_range(0, 1));
                    2: rsp.ready <= ($urandom_range(0, 3) != 0);
                    default: rsp.ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int pick;
        int work_beats;
        req.valid        <= 1'b0;
        req.command      <= sst_pkg::CMD_LOOKUP;
        req.symbol_index <= '0;
        req.decl_id      <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: misses on an empty map while all_ok is still high
        issue(sst_pkg::CMD_LOOKUP, '0, '1);
        issue(sst_pkg::CMD_CLASH_TEST, '1, '0);
        // an outermost binding, then a clash at the same level
        issue(sst_pkg::CMD_INSERT, '1, '1);
        issue(sst_pkg::CMD_INSERT, '1, 12'h123);
        issue(sst_pkg::CMD_LOOKUP, '1, '0);
        // close with nothing open
        issue(sst_pkg::CMD_CLOSE, '0, '0);
        issue(sst_pkg::CMD_OPEN, '0, '0);
        // bound one level out, so the clash test misses and insert shadows
        issue(sst_pkg::CMD_CLASH_TEST, '1, '0);
        issue(sst_pkg::CMD_INSERT, '1, '0);
        issue(sst_pkg::CMD_LOOKUP, '1, '1);
        issue(sst_pkg::CMD_CLASH_TEST, '1, '0);
        issue(sst_pkg::CMD_INSERT, '0, '1);
        issue(sst_pkg::CMD_INSERT, '0, 12'hAAA);
        // ignored codes with busy fields
        issue(ignored_cmd(1), '1, '1);
        issue(ignored_cmd(2), 10'h2AA, 12'h555);
        issue(ignored_cmd(3), 10'h155, 12'hAAA);
        // second level shadows again, closes restore in order
        issue(sst_pkg::CMD_OPEN, '0, '0);
        issue(sst_pkg::CMD_INSERT, '1, 12'hAAA);
        issue(sst_pkg::CMD_INSERT, 10'h155, 12'h555);
        issue(sst_pkg::CMD_CLOSE, '0, '0);
        issue(sst_pkg::CMD_LOOKUP, '1, '0);
        issue(sst_pkg::CMD_CLOSE, '0, '0);
        issue(sst_pkg::CMD_LOOKUP, '1, '0);
        issue(sst_pkg::CMD_LOOKUP, '0, '0);

        // climb past both limits: scope stack full and declaration stack full
        for (int lvl = 0; lvl < SCOPE_LIMIT + 6; lvl++)
        begin
            issue(sst_pkg::CMD_OPEN, pick_symbol(), DECL_W'($urandom));
            repeat (4)
                issue(sst_pkg::CMD_INSERT, SYM_W'($urandom_range(0, SYMBOLS - 1)),
                      DECL_W'($urandom));
            if (lvl % 8 == 0)
                issue(sst_pkg::CMD_LOOKUP, pick_symbol(), '0);
        end
        // unwind every level, each close walking the entries of its level, then underflow
        repeat (SCOPE_LIMIT + 2)
            issue(sst_pkg::CMD_CLOSE, pick_symbol(), DECL_W'($urandom));

        // random mix steered by the nesting level we think we are at
        work_beats = 0;
        while (work_beats < RANDOM_BEATS)
        begin
            pick = $urandom_range(0, 99);
            if (level_seen == 0)
            begin
                if (pick < 55)
                    issue(sst_pkg::CMD_OPEN, pick_symbol(), DECL_W'($urandom));
                else if (pick < 58)
                    issue(sst_pkg::CMD_INSERT, pick_symbol(), DECL_W'($urandom));
                else if (pick < 70)
                    issue(sst_pkg::CMD_CLOSE, pick_symbol(), DECL_W'($urandom));
                else if (pick < 82)
                    issue(sst_pkg::CMD_LOOKUP, pick_symbol(), DECL_W'($urandom));
                else if (pick < 94)
                    issue(sst_pkg::CMD_CLASH_TEST, pick_symbol(), DECL_W'($urandom));
                else
                    issue(ignored_cmd($urandom_range(1, 3)), pick_symbol(),
                          DECL_W'($urandom));
            end
            else
            begin
                if (pick < 14)
                    issue(sst_pkg::CMD_OPEN, pick_symbol(), DECL_W'($urandom));
                else if (pick < 27)
                    issue(sst_pkg::CMD_CLOSE, pick_symbol(), DECL_W'($urandom));
                else if (pick < 60)
                    issue(sst_pkg::CMD_INSERT, pick_symbol(), DECL_W'($urandom));
                else if (pick < 80)
                    issue(sst_pkg::CMD_LOOKUP, pick_symbol(), DECL_W'($urandom));
                else if (pick < 96)
                    issue(sst_pkg::CMD_CLASH_TEST, pick_symbol(), DECL_W'($urandom));
                else
                    issue(ignored_cmd($urandom_range(1, 3)), pick_symbol(),
                          DECL_W'($urandom));
            end
            if (req.command <= sst_pkg::CMD_CLASH_TEST)
                work_beats++;
        end
        req.valid <= 1'b0;

        // drain outstanding results, then give a late close time to misbehave
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_beats == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
